[rtl/core/hbr_pkg.sv]
package hbr_pkg;

    // fixed field widths
    localparam int PIX_W       = 12;
    localparam int BIN_VAL_W   = 24;
    localparam int PIX_VAL_W   = 8;
    localparam int CFG_DIM_W   = 13;
    localparam int CFG_BINS_W  = 9;
    localparam int CFG_SCALE_W = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int SCALE_FRAC  = 12;

    // parameter defaults
    localparam int DEF_MAX_BINS   = 256;
    localparam int DEF_COUNT_BITS = 24;
    localparam int DEF_MAX_DIM    = 4096;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_USED    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SCALE    = 2'd3;

    // register reset values
    localparam logic [CFG_DIM_W-1:0]   RST_IMAGE_WIDTH  = 13'd256;
    localparam logic [CFG_DIM_W-1:0]   RST_IMAGE_HEIGHT = 13'd256;
    localparam logic [CFG_BINS_W-1:0]  RST_BINS_USED    = 9'd256;
    localparam logic [CFG_SCALE_W-1:0] RST_MAX_SCALE    = 16'd4096;

    // item modes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // gray levels
    localparam logic [PIX_VAL_W-1:0] PIX_BACKGROUND = 8'd225;
    localparam logic [PIX_VAL_W-1:0] PIX_BAR        = 8'd0;

    // zero reads as one, values above the limit saturate
    function automatic logic [31:0] clamp_reg(input logic [31:0] v, input logic [31:0] hi);
        logic [31:0] r;
        if (v == 32'd0)
        begin
            r = 32'd1;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

[rtl/core/hbr_in_if.sv]
interface hbr_in_if import hbr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [BIN_VAL_W-1:0] bin_value;
    logic                 last_bin;
    logic [PIX_W-1:0]     pixel_x;
    logic [PIX_W-1:0]     pixel_y;

    modport source (output valid, mode, bin_value, last_bin, pixel_x, pixel_y, input ready);
    modport sink (input valid, mode, bin_value, last_bin, pixel_x, pixel_y, output ready);
endinterface

[rtl/core/hbr_out_if.sv]
interface hbr_out_if import hbr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [PIX_VAL_W-1:0] pixel_value;
    logic                 in_bar;

    modport source (output valid, pixel_value, in_bar, input ready);
    modport sink (input valid, pixel_value, in_bar, output ready);
endinterface

[rtl/core/hbr_divider.sv]
module hbr_divider import hbr_pkg::*; #(
    parameter int DVD_W = 37,
    parameter int DVS_W = 29
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;

    logic [DVS_W:0]   shift;
    logic [DVS_W:0]   diff;
    logic             fits;

    // one quotient bit per cycle, restoring
    assign shift = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = shift - {1'b0, dvs_reg};
    assign fits  = shift >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DVS_W-1:0] : shift[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/core/histogram_bar_renderer_core.sv]
// load item: the last bin of a load holds the block through S_SCALE and S_SCALE_WB
// while the peak is scaled through the shared multiplier
// pixel query inside the image: S_MUL1, S_DIV1, S_WAIT1, S_READ, S_DIV2, S_WAIT2, S_FINISH,
// with two passes of the bit-serial divider, one quotient bit per cycle
// pixel query outside the image: straight to S_FINISH; one item in flight, result held in an output register
// reset: registers to defaults, load state cleared, bin memory left unwritten
module histogram_bar_renderer_core import hbr_pkg::*; #(
    parameter int MAX_BINS   = DEF_MAX_BINS,
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int MAX_DIM    = DEF_MAX_DIM
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    hbr_in_if.sink                req,
    hbr_out_if.source             rsp
);

    localparam int ADDR_W  = $clog2(MAX_BINS);
    localparam int NB_W    = $clog2(MAX_BINS + 1);
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int SP_W    = COUNT_BITS + 4;
    localparam int XP_W    = PIX_W + 1;
    localparam int CMP_W   = (DIM_W > XP_W) ? DIM_W : XP_W;
    localparam int MA_0    = (COUNT_BITS > XP_W) ? COUNT_BITS : XP_W;
    localparam int MUL_A_W = (MA_0 > DIM_W) ? MA_0 : DIM_W;
    localparam int MB_0    = (CFG_SCALE_W > NB_W) ? CFG_SCALE_W : NB_W;
    localparam int MUL_B_W = (MB_0 > DIM_W) ? MB_0 : DIM_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DV_0    = XP_W + NB_W;
    localparam int DV_1    = COUNT_BITS + DIM_W;
    localparam int DVD_W   = (DV_0 > DV_1) ? DV_0 : DV_1;
    localparam int DVS_W   = (DIM_W > SP_W + 1) ? DIM_W : SP_W + 1;
    localparam logic [31:0] VAL_MASK = (COUNT_BITS >= 32) ? 32'hFFFF_FFFF :
                                       32'((64'd1 << COUNT_BITS) - 64'd1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCALE    = 4'd1;
    localparam logic [3:0] S_SCALE_WB = 4'd2;
    localparam logic [3:0] S_MUL1     = 4'd3;
    localparam logic [3:0] S_DIV1     = 4'd4;
    localparam logic [3:0] S_WAIT1    = 4'd5;
    localparam logic [3:0] S_READ     = 4'd6;
    localparam logic [3:0] S_DIV2     = 4'd7;
    localparam logic [3:0] S_WAIT2    = 4'd8;
    localparam logic [3:0] S_FINISH   = 4'd9;

    logic [3:0]             state_reg, state_next;
    logic [CFG_DIM_W-1:0]   image_width_reg, image_width_next;
    logic [CFG_DIM_W-1:0]   image_height_reg, image_height_next;
    logic [CFG_BINS_W-1:0]  bins_used_reg, bins_used_next;
    logic [CFG_SCALE_W-1:0] max_scale_reg, max_scale_next;
    logic [ADDR_W-1:0]      load_index_reg, load_index_next;
    logic [COUNT_BITS-1:0]  peak_reg, peak_next;
    logic [SP_W-1:0]        scaled_peak_reg, scaled_peak_next;
    logic                   load_done_reg, load_done_next;
    logic                   out_valid_reg, out_valid_next;

    logic [PIX_W-1:0]       x_reg, x_next;
    logic [PIX_W-1:0]       y_reg, y_next;
    logic                   bar_reg, bar_next;
    logic [PIX_VAL_W-1:0]   pix_out_reg, pix_out_next;
    logic                   in_bar_out_reg, in_bar_out_next;
    logic [PROD_W-1:0]      prod_reg;
    logic [COUNT_BITS-1:0]  bin_rd_reg;

    logic [COUNT_BITS-1:0]  bin_mem [MAX_BINS];

    logic [31:0]            w32, h32, n32, v32;
    logic [DIM_W-1:0]       w, h, hm1;
    logic [NB_W-1:0]        n;
    logic [COUNT_BITS-1:0]  v;
    logic                   accept;
    logic                   in_image;
    logic [ADDR_W-1:0]      load_addr;
    logic [COUNT_BITS-1:0]  base_peak;
    logic [ADDR_W:0]        addr_p1;
    logic                   mem_we;
    logic                   mem_re;
    logic [DVD_W-1:0]       bin_full;
    logic [ADDR_W-1:0]      rd_addr;
    logic [MUL_A_W-1:0]     mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    logic                   div_start;
    logic [DVD_W-1:0]       div_dvd;
    logic [DVS_W-1:0]       div_dvs;
    logic                   div_done;
    logic [DVD_W-1:0]       div_quo;
    logic [DIM_W-1:0]       top;

    assign w32 = clamp_reg(32'(image_width_reg), 32'(MAX_DIM));
    assign h32 = clamp_reg(32'(image_height_reg), 32'(MAX_DIM));
    assign n32 = clamp_reg(32'(bins_used_reg), 32'(MAX_BINS));
    assign w   = w32[DIM_W-1:0];
    assign h   = h32[DIM_W-1:0];
    assign n   = n32[NB_W-1:0];
    assign hm1 = h - DIM_W'(1);

    assign v32 = 32'(req.bin_value) & VAL_MASK;
    assign v   = v32[COUNT_BITS-1:0];

    assign accept   = req.valid && (state_reg == S_IDLE);
    assign in_image = (CMP_W'(req.pixel_x) < CMP_W'(w)) && (CMP_W'(req.pixel_y) < CMP_W'(h));

    // a load item after a finished load restarts at bin zero
    assign load_addr = load_done_reg ? '0 : load_index_reg;
    assign base_peak = load_done_reg ? '0 : peak_reg;
    assign addr_p1   = {1'b0, load_addr} + (ADDR_W + 1)'(1);
    assign mem_we    = accept && (req.mode == MODE_LOAD);

    // bin lookup, quotient is below n inside the image but clamp anyway
    assign bin_full = (div_quo >= DVD_W'(n)) ? DVD_W'(n) - DVD_W'(1) : div_quo;
    assign rd_addr  = bin_full[ADDR_W-1:0];
    assign mem_re   = (state_reg == S_WAIT1) && div_done;

    assign top = hm1 - div_quo[DIM_W-1:0];

    // shared multiplier operands
    always_comb
    begin
        case (state_reg)
            S_SCALE:
            begin
                mul_a = MUL_A_W'(peak_reg);
                mul_b = MUL_B_W'(max_scale_reg);
            end
            S_MUL1:
            begin
                mul_a = MUL_A_W'(x_reg) + MUL_A_W'(1);
                mul_b = MUL_B_W'(n);
            end
            S_READ:
            begin
                mul_a = MUL_A_W'(bin_rd_reg);
                mul_b = MUL_B_W'(hm1);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // shared divider operands
    always_comb
    begin
        case (state_reg)
            S_DIV1:
            begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(prod_reg - PROD_W'(1));
                div_dvs   = DVS_W'(w);
            end
            S_DIV2:
            begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(prod_reg);
                div_dvs   = DVS_W'(scaled_peak_reg) + DVS_W'(1);
            end
            default:
            begin
                div_start = 1'b0;
                div_dvd   = '0;
                div_dvs   = '0;
            end
        endcase
    end

    hbr_divider #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next        = state_reg;
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        bins_used_next    = bins_used_reg;
        max_scale_next    = max_scale_reg;
        load_index_next   = load_index_reg;
        peak_next         = peak_reg;
        scaled_peak_next  = scaled_peak_reg;
        load_done_next    = load_done_reg;
        out_valid_next    = out_valid_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        bar_next          = bar_reg;
        pix_out_next      = pix_out_reg;
        in_bar_out_next   = in_bar_out_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_next  = cfg_data[CFG_DIM_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_next = cfg_data[CFG_DIM_W-1:0];
                CFG_BINS_USED:    bins_used_next    = cfg_data[CFG_BINS_W-1:0];
                CFG_MAX_SCALE:    max_scale_next    = cfg_data[CFG_SCALE_W-1:0];
                default:          ;
            endcase
        end

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.mode == MODE_LOAD)
                    begin
                        peak_next       = (v > base_peak) ? v : base_peak;
                        load_index_next = (addr_p1 == (ADDR_W + 1)'(MAX_BINS)) ?
                                          '0 : addr_p1[ADDR_W-1:0];
                        load_done_next  = 1'b0;
                        if (req.last_bin)
                        begin
                            state_next = S_SCALE;
                        end
                    end
                    else
                    begin
                        x_next = req.pixel_x;
                        y_next = req.pixel_y;
                        if (in_image)
                        begin
                            state_next = S_MUL1;
                        end
                        else
                        begin
                            bar_next   = 1'b0;
                            state_next = S_FINISH;
                        end
                    end
                end
            end
            S_SCALE:
            begin
                state_next = S_SCALE_WB;
            end
            S_SCALE_WB:
            begin
                scaled_peak_next = prod_reg[SCALE_FRAC +: SP_W];
                load_done_next   = 1'b1;
                state_next       = S_IDLE;
            end
            S_MUL1:
            begin
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                state_next = S_WAIT1;
            end
            S_WAIT1:
            begin
                if (div_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                state_next = S_WAIT2;
            end
            S_WAIT2:
            begin
                if (div_done)
                begin
                    // a drop that reaches the top row clamps the bar top at row 0
                    if (div_quo >= DVD_W'(hm1))
                    begin
                        bar_next = (y_reg != '0);
                    end
                    else
                    begin
                        bar_next = CMP_W'(y_reg) > CMP_W'(top);
                    end
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    pix_out_next    = bar_reg ? PIX_BAR : PIX_BACKGROUND;
                    in_bar_out_next = bar_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            bins_used_reg    <= RST_BINS_USED;
            max_scale_reg    <= RST_MAX_SCALE;
            load_index_reg   <= '0;
            peak_reg         <= '0;
            scaled_peak_reg  <= '0;
            load_done_reg    <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            bins_used_reg    <= bins_used_next;
            max_scale_reg    <= max_scale_next;
            load_index_reg   <= load_index_next;
            peak_reg         <= peak_next;
            scaled_peak_reg  <= scaled_peak_next;
            load_done_reg    <= load_done_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        y_reg          <= y_next;
        bar_reg        <= bar_next;
        pix_out_reg    <= pix_out_next;
        in_bar_out_reg <= in_bar_out_next;
        prod_reg       <= mul_a * mul_b;
    end

    // bin count store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bin_mem[load_addr] <= v;
        end
        if (mem_re)
        begin
            bin_rd_reg <= bin_mem[rd_addr];
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.pixel_value = pix_out_reg;
    assign rsp.in_bar      = in_bar_out_reg;

endmodule

[verif/bar_pixel_checker.sv]
`timescale 1ns / 1ps
module bar_pixel_checker import hbr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    hbr_in_if                     req,
    hbr_out_if                    rsp,
    output int                    mismatches,
    output int                    waiting,
    output int                    pixels_checked,
    output int                    bar_pixels
);

    localparam int BINS      = DEF_MAX_BINS;
    localparam int DIM_LIMIT = DEF_MAX_DIM;

    typedef struct packed {
        logic [PIX_W-1:0]     x;
        logic [PIX_W-1:0]     y;
        logic [PIX_VAL_W-1:0] gray;
        logic                 bar;
    } pixel_t;

    logic [BIN_VAL_W-1:0]    bar_counts [BINS];
    logic [$clog2(BINS)-1:0] fill_ptr;
    logic [BIN_VAL_W-1:0]    running_peak;
    logic [BIN_VAL_W+3:0]    peak_scaled;
    logic                    fill_closed;
    logic [CFG_DIM_W-1:0]    cfg_w;
    logic [CFG_DIM_W-1:0]    cfg_h;
    logic [CFG_BINS_W-1:0]   cfg_n;
    logic [CFG_SCALE_W-1:0]  cfg_scale;
    pixel_t                  expected_pixels [$];
    pixel_t                  want;

    function automatic longint unsigned effective(input longint unsigned raw,
                                                  input longint unsigned hi);
        if (raw == 0)
        begin
            return 1;
        end
        return (raw > hi) ? hi : raw;
    endfunction

    function automatic pixel_t render_pixel(input logic [PIX_W-1:0] x,
                                            input logic [PIX_W-1:0] y);
        longint unsigned w, h, n, xx, yy, col_bin, cnt, drop, bar_top;
        pixel_t p;
        w  = effective(64'(cfg_w), 64'(DIM_LIMIT));
        h  = effective(64'(cfg_h), 64'(DIM_LIMIT));
        n  = effective(64'(cfg_n), 64'(BINS));
        xx = 64'(x);
        yy = 64'(y);
        p.x    = x;
        p.y    = y;
        p.gray = PIX_BACKGROUND;
        p.bar  = 1'b0;
        if (xx < w && yy < h)
        begin
            // bin whose column span holds x
            col_bin = ((xx + 1) * n - 1) / w;
            if (col_bin >= n)
            begin
                col_bin = n - 1;
            end
            cnt  = 64'(bar_counts[col_bin]);
            drop = (cnt * (h - 1)) / (64'(peak_scaled) + 1);
            bar_top = (drop >= h - 1) ? 0 : (h - 1) - drop;
            if (yy > bar_top)
            begin
                p.gray = PIX_BAR;
                p.bar  = 1'b1;
            end
        end
        return p;
    endfunction

    task automatic take_bin(input logic [BIN_VAL_W-1:0] value, input logic last);
        longint unsigned product;
        if (fill_closed)
        begin
            fill_ptr     = '0;
            running_peak = '0;
            fill_closed  = 1'b0;
        end
        bar_counts[fill_ptr] = value;
        if (value > running_peak)
        begin
            running_peak = value;
        end
        fill_ptr = fill_ptr + 1'b1;
        if (last)
        begin
            product     = 64'(running_peak) * 64'(cfg_scale);
            peak_scaled = (BIN_VAL_W + 4)'(product >> SCALE_FRAC);
            fill_closed = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40)
        begin
            $display("[%0t] pixel mismatch: %s", $time, what);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w          = RST_IMAGE_WIDTH;
            cfg_h          = RST_IMAGE_HEIGHT;
            cfg_n          = RST_BINS_USED;
            cfg_scale      = RST_MAX_SCALE;
            fill_ptr       = '0;
            running_peak   = '0;
            peak_scaled    = '0;
            fill_closed    = 1'b1;
            expected_pixels.delete();
            mismatches     = 0;
            waiting        = 0;
            pixels_checked = 0;
            bar_pixels     = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  cfg_w     = cfg_data[CFG_DIM_W-1:0];
                    CFG_IMAGE_HEIGHT: cfg_h     = cfg_data[CFG_DIM_W-1:0];
                    CFG_BINS_USED:    cfg_n     = cfg_data[CFG_BINS_W-1:0];
                    CFG_MAX_SCALE:    cfg_scale = cfg_data[CFG_SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
            begin
                if (req.mode == MODE_LOAD)
                begin
                    take_bin(req.bin_value, req.last_bin);
                end
                else
                begin
                    expected_pixels.push_back(render_pixel(req.pixel_x, req.pixel_y));
                end
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d/%0d with no query waiting",
                                              rsp.pixel_value, rsp.in_bar));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    pixels_checked++;
                    if (want.bar)
                    begin
                        bar_pixels++;
                    end
                    if (rsp.pixel_value !== want.gray)
                    begin
                        report_mismatch($sformatf("(%0d,%0d) pixel_value %0d, predicted %0d",
                                                  want.x, want.y, rsp.pixel_value, want.gray));
                    end
                    if (rsp.in_bar !== want.bar)
                    begin
                        report_mismatch($sformatf("(%0d,%0d) in_bar %0d, predicted %0d",
                                                  want.x, want.y, rsp.in_bar, want.bar));
                    end
                end
            end
            waiting = expected_pixels.size();
        end
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import hbr_pkg::*;

    localparam int RUN_ITEMS     = 1350;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int STALL_HOLD    = 400;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hbr_in_if  req_ch ();
    hbr_out_if rsp_ch ();

    int mismatches;
    int waiting;
    int pixels_checked;
    int bar_pixels;
    int items_sent;
    int loads_sent;
    int queries_sent;
    int reg_writes;
    int setups;
    int eff_w;
    int eff_h;
    int eff_n;
    bit rsp_hold;

    histogram_bar_renderer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    bar_pixel_checker pixel_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatches     (mismatches),
        .waiting        (waiting),
        .pixels_checked (pixels_checked),
        .bar_pixels     (bar_pixels)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d items sent", cycles, items_sent);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int eff_of(input int raw, input int bits, input int hi);
        int v;
        v = raw & ((1 << bits) - 1);
        if (v == 0)
        begin
            v = 1;
        end
        else if (v > hi)
        begin
            v = hi;
        end
        return v;
    endfunction

    // mostly short stalls, a few long ones
    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 95)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [BIN_VAL_W-1:0] rand_count();
        case ($urandom_range(0, 9))
            5, 6:    return BIN_VAL_W'($urandom_range(0, 255));
            7:       return '0;
            8:       return {BIN_VAL_W{1'b1}};
            9:       return BIN_VAL_W'($urandom_range(0, 4095) << 12);
            default: return BIN_VAL_W'($urandom());
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_IMAGE_WIDTH:  eff_w = eff_of(int'(data), CFG_DIM_W, DEF_MAX_DIM);
            CFG_IMAGE_HEIGHT: eff_h = eff_of(int'(data), CFG_DIM_W, DEF_MAX_DIM);
            CFG_BINS_USED:    eff_n = eff_of(int'(data), CFG_BINS_W, DEF_MAX_BINS);
            default: ;
        endcase
    endtask

    task automatic send_item(input logic mode, input logic [BIN_VAL_W-1:0] value,
                             input logic last, input logic [PIX_W-1:0] x,
                             input logic [PIX_W-1:0] y);
        int gap;
        @(negedge clk);
        req_ch.valid     <= 1'b1;
        req_ch.mode      <= mode;
        req_ch.bin_value <= value;
        req_ch.last_bin  <= last;
        req_ch.pixel_x   <= x;
        req_ch.pixel_y   <= y;
        do @(posedge clk); while (!req_ch.ready);
        items_sent++;
        if (mode == MODE_LOAD)
        begin
            loads_sent++;
        end
        else
        begin
            queries_sent++;
        end
        // every fourth stretch of items goes back to back
        gap = 0;
        if ((items_sent / 150) % 4 != 3 && $urandom_range(0, 99) >= 65)
        begin
            gap = stall_len();
        end
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid     <= 1'b0;
            req_ch.mode      <= 1'($urandom_range(0, 1));
            req_ch.bin_value <= BIN_VAL_W'($urandom());
            req_ch.pixel_x   <= PIX_W'($urandom());
            req_ch.pixel_y   <= PIX_W'($urandom());
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic load_bin(input logic [BIN_VAL_W-1:0] value, input logic last);
        send_item(MODE_LOAD, value, last, PIX_W'($urandom()), PIX_W'($urandom()));
    endtask

    task automatic query_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
        send_item(MODE_QUERY, BIN_VAL_W'($urandom()), 1'($urandom_range(0, 1)), x, y);
    endtask

    task automatic random_query();
        if ($urandom_range(0, 99) < 80)
        begin
            query_pixel(PIX_W'($urandom_range(0, eff_w - 1)),
                        PIX_W'($urandom_range(0, eff_h - 1)));
        end
        else
        begin
            query_pixel(PIX_W'($urandom()), PIX_W'($urandom()));
        end
    endtask

    // block idle: nothing waiting and the last bin scaling done
    task automatic settle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (waiting != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic random_setup(input bit every_reg);
        logic [CFG_DATA_W-1:0] v;
        settle();
        setups++;
        if (every_reg || $urandom_range(0, 1))
        begin
            case ($urandom_range(0, 7))
                0:       v = 0;
                1:       v = 1;
                2:       v = CFG_DATA_W'($urandom_range(2, 16));
                3:       v = CFG_DATA_W'($urandom_range(1, 300));
                4:       v = CFG_DATA_W'($urandom_range(1, 4096));
                5:       v = 4096;
                6:       v = CFG_DATA_W'($urandom_range(4097, 8191));
                default: v = 16'hFFFF;
            endcase
            write_reg(CFG_IMAGE_WIDTH, v);
        end
        if (every_reg || $urandom_range(0, 1))
        begin
            case ($urandom_range(0, 7))
                0:       v = 0;
                1:       v = 1;
                2:       v = CFG_DATA_W'($urandom_range(2, 16));
                3:       v = CFG_DATA_W'($urandom_range(1, 300));
                4:       v = CFG_DATA_W'($urandom_range(1, 4096));
                5:       v = 4096;
                6:       v = CFG_DATA_W'($urandom_range(4097, 8191));
                default: v = 16'hFFFF;
            endcase
            write_reg(CFG_IMAGE_HEIGHT, v);
        end
        if (every_reg || $urandom_range(0, 1))
        begin
            case ($urandom_range(0, 7))
                0:       v = 0;
                1:       v = 1;
                2:       v = 2;
                3:       v = CFG_DATA_W'($urandom_range(3, 16));
                4:       v = CFG_DATA_W'($urandom_range(1, 64));
                5:       v = 256;
                6:       v = CFG_DATA_W'($urandom_range(257, 511));
                default: v = 16'hFFFF;
            endcase
            write_reg(CFG_BINS_USED, v);
        end
        if (every_reg || $urandom_range(0, 1))
        begin
            case ($urandom_range(0, 7))
                0:       v = 0;
                1:       v = 1;
                2:       v = 4096;
                3:       v = 16'hFFFF;
                default: v = CFG_DATA_W'($urandom_range(1, 65535));
            endcase
            write_reg(CFG_MAX_SCALE, v);
        end
    endtask

    // long receiver hold-off while the sender keeps offering
    initial
    begin
        rsp_hold = 1'b0;
        wait (items_sent >= 600);
        @(posedge clk);
        rsp_hold = 1'b1;
        repeat (STALL_HOLD) @(posedge clk);
        rsp_hold = 1'b0;
    end

    initial
    begin : rsp_driver
        int gap_left;
        int cycles;
        rsp_ch.ready = 1'b0;
        gap_left = 0;
        cycles = 0;
        forever
        begin
            @(negedge clk);
            cycles++;
            if (rsp_hold || gap_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                end
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ((cycles / 300) % 3 != 2 && $urandom_range(0, 99) < 20)
                begin
                    gap_left = stall_len();
                end
            end
        end
    end

    initial
    begin : stimulus
        int len;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_IMAGE_WIDTH;
        cfg_data         = '0;
        req_ch.valid     = 1'b0;
        req_ch.mode      = MODE_LOAD;
        req_ch.bin_value = '0;
        req_ch.last_bin  = 1'b0;
        req_ch.pixel_x   = '0;
        req_ch.pixel_y   = '0;
        items_sent       = 0;
        loads_sent       = 0;
        queries_sent     = 0;
        reg_writes       = 0;
        setups           = 1;
        eff_w            = int'(RST_IMAGE_WIDTH);
        eff_h            = int'(RST_IMAGE_HEIGHT);
        eff_n            = int'(RST_BINS_USED);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // small picture, four bins with count extremes
        write_reg(CFG_IMAGE_WIDTH, 8);
        write_reg(CFG_IMAGE_HEIGHT, 16);
        write_reg(CFG_BINS_USED, 4);
        write_reg(CFG_MAX_SCALE, 4096);
        load_bin(24'hFFFFFF, 1'b0);
        load_bin(24'h000000, 1'b0);
        load_bin(24'h800000, 1'b0);
        load_bin(24'h000001, 1'b1);
        query_pixel(0, 0);
        query_pixel(1, 2);
        query_pixel(1, 1);
        query_pixel(2, 15);
        query_pixel(4, 9);
        query_pixel(7, 15);
        query_pixel(8, 0);
        query_pixel(0, 16);
        query_pixel(12'hFFF, 12'hFFF);
        // query while a new load is in progress
        load_bin(24'h00ABCD, 1'b0);
        query_pixel(0, 15);
        load_bin(24'h5A5A5A, 1'b1);

        // tiny scale gives bars taller than the image; more bins than columns
        settle();
        setups++;
        write_reg(CFG_MAX_SCALE, 1);
        write_reg(CFG_IMAGE_WIDTH, 3);
        load_bin(24'h003000, 1'b0);
        load_bin(24'h000010, 1'b0);
        load_bin(24'h002000, 1'b0);
        load_bin(24'h000001, 1'b1);
        query_pixel(0, 1);
        query_pixel(1, 0);
        query_pixel(2, 15);

        // largest picture; a load longer than the store fills every bin and wraps
        settle();
        setups++;
        write_reg(CFG_IMAGE_WIDTH, 4096);
        write_reg(CFG_IMAGE_HEIGHT, 4096);
        write_reg(CFG_BINS_USED, 256);
        write_reg(CFG_MAX_SCALE, 16'hFFFF);
        for (int i = 0; i < 260; i++)
        begin
            load_bin(rand_count(), i == 259);
        end
        repeat (20) random_query();

        while (items_sent < RUN_ITEMS)
        begin
            random_setup(setups < 6);
            repeat ($urandom_range(3, 8))
            begin
                if ($urandom_range(0, 99) < 75)
                begin
                    len = $urandom_range(1, 48);
                    if (len > eff_n || $urandom_range(0, 2) == 0)
                    begin
                        len = (eff_n < 48) ? eff_n : len;
                    end
                    if ($urandom_range(0, 99) < 3)
                    begin
                        len = $urandom_range(257, 300);
                    end
                    for (int i = 0; i < len; i++)
                    begin
                        load_bin(rand_count(), i == len - 1);
                        if ($urandom_range(0, 99) < 8)
                        begin
                            random_query();
                        end
                    end
                end
                else
                begin
                    // a load left open: later queries see a half-written store
                    repeat ($urandom_range(1, 6)) load_bin(rand_count(), 1'b0);
                end
                repeat ($urandom_range(2, 12)) random_query();
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d loads and %0d pixel queries over %0d setups (%0d register writes)",
                 loads_sent, queries_sent, setups, reg_writes);
        $display("%0d pixels compared, %0d of them inside a bar", pixels_checked, bar_pixels);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/hbr_pkg.sv
rtl/core/hbr_in_if.sv
rtl/core/hbr_out_if.sv
rtl/core/hbr_divider.sv
rtl/core/histogram_bar_renderer_core.sv
verif/bar_pixel_checker.sv
verif/testbench.sv
